### hw/rtl/crtc_fv_pkg.sv
package crtc_fv_pkg;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int CYC_W    = 32;
  localparam int IDX_W    = 8;
  localparam int DATA_W   = 16;
  localparam int RASTER_W = 10;
  localparam int POS_W    = 18;

  // Default timing and register file geometry
  localparam int FRAME_CYCLES_DEF  = 180342;
  localparam int VBLANK_CYCLES_DEF = 12680;
  localparam int RASTER_COUNT_DEF  = 568;
  localparam int REG_COUNT_DEF     = 24;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

endpackage

### hw/rtl/crtc_fv_ram.sv
module crtc_fv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 24
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/crtc_fv_modred.sv
module crtc_fv_modred #(
  parameter int FRAME_CYCLES = crtc_fv_pkg::FRAME_CYCLES_DEF
) (
  input  logic [crtc_fv_pkg::CYC_W-1:0] cycles,
  output logic [crtc_fv_pkg::POS_W-1:0] residue
);

  localparam int PW = crtc_fv_pkg::POS_W;
  localparam int BYTES = crtc_fv_pkg::CYC_W / 8;
  localparam logic [PW+1:0] F1 = (PW+2)'(FRAME_CYCLES);
  localparam logic [PW+1:0] F2 = (PW+2)'(2 * FRAME_CYCLES);
  localparam logic [PW+1:0] F3 = (PW+2)'(3 * FRAME_CYCLES);

  // Residue of each byte at its weight, one constant table per byte lane
  logic [PW-1:0] tab  [BYTES][256];
  logic [PW-1:0] part [BYTES];
  logic [PW+1:0] sum;

  for (genvar k = 0; k < BYTES; k++) begin : g_lane
    for (genvar i = 0; i < 256; i++) begin : g_entry
      localparam longint RES = (longint'(i) << (8 * k)) % FRAME_CYCLES;
      assign tab[k][i] = PW'(RES);
    end
    assign part[k] = tab[k][cycles[8*k +: 8]];
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < BYTES; k++) begin
      sum = sum + {2'b00, part[k]};
    end
  end

  // Sum of four residues stays below four frames: fold back once
  always_comb begin
    priority if (sum >= F3) begin
      residue = PW'(sum - F3);
    end else if (sum >= F2) begin
      residue = PW'(sum - F2);
    end else if (sum >= F1) begin
      residue = PW'(sum - F1);
    end else begin
      residue = PW'(sum);
    end
  end

endmodule

### hw/rtl/crtc_fv_raster.sv
module crtc_fv_raster #(
  parameter int FRAME_CYCLES = crtc_fv_pkg::FRAME_CYCLES_DEF,
  parameter int RASTER_COUNT = crtc_fv_pkg::RASTER_COUNT_DEF
) (
  input  logic [crtc_fv_pkg::POS_W-1:0]    position,
  output logic [crtc_fv_pkg::RASTER_W-1:0] raster
);

  localparam int     PW    = crtc_fv_pkg::POS_W;
  localparam int     RW    = crtc_fv_pkg::RASTER_W;
  // 2^SHIFT >= FRAME_CYCLES^2 keeps the rounded-up reciprocal exact
  localparam int     SHIFT = 2 * $clog2(FRAME_CYCLES);
  localparam longint MULT  =
    ((longint'(1) << SHIFT) * RASTER_COUNT + FRAME_CYCLES - 1) / FRAME_CYCLES;
  localparam int     MW    = $clog2(MULT + 1);
  localparam int     PRW   = (PW + MW > SHIFT + RW) ? PW + MW : SHIFT + RW;

  logic [PRW-1:0] prod;

  assign prod   = PRW'(position) * PRW'(MULT);
  assign raster = prod[SHIFT +: RW];

endmodule

### hw/rtl/crtc_frame_timer_with_vblank_top.sv
// CRTC frame timer with vertical blank and a 16-bit register file.
//
// Request channel (req_valid / req_stall): one operation per request, a tick
// (advance the frame position by cycles modulo the frame), a register read or
// a register write. Response channel (rsp_valid / rsp_stall): exactly one
// response per request, in order, carrying read_data, vblank_changed,
// in_vblank and raster (frame position scaled to RASTER_COUNT lines).
//
// Three register stages: request capture (cycles folded into one frame),
// state update (position, vblank level, register file access) and the
// response register (raster scaling by one constant multiplier).
// A response is registered once its request has left the state-update stage.
// Throughput is one request per cycle while rsp_stall is low; the position
// feedback loop is a single add with one fold back into the frame.
//
// Reset clears the position, the vblank level, all pipeline valids and the
// register file valid bits, so every register reads as zero until written.
// When the receiver stalls, the response holds and empty stages still fill:
// up to three requests are taken before req_stall rises.
module crtc_frame_timer_with_vblank_top #(
  parameter int FRAME_CYCLES  = crtc_fv_pkg::FRAME_CYCLES_DEF,
  parameter int VBLANK_CYCLES = crtc_fv_pkg::VBLANK_CYCLES_DEF,
  parameter int RASTER_COUNT  = crtc_fv_pkg::RASTER_COUNT_DEF,
  parameter int REG_COUNT     = crtc_fv_pkg::REG_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [crtc_fv_pkg::OP_W-1:0]     operation,
  input  logic [crtc_fv_pkg::CYC_W-1:0]    cycles,
  input  logic [crtc_fv_pkg::IDX_W-1:0]    reg_index,
  input  logic [crtc_fv_pkg::DATA_W-1:0]   write_value,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [crtc_fv_pkg::DATA_W-1:0]   read_data,
  output logic                             vblank_changed,
  output logic                             in_vblank,
  output logic [crtc_fv_pkg::RASTER_W-1:0] raster
);

  localparam int PW = crtc_fv_pkg::POS_W;
  localparam int DW = crtc_fv_pkg::DATA_W;
  localparam int IW = crtc_fv_pkg::IDX_W;
  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  localparam logic [PW:0]   FRAME_LEN = (PW+1)'(FRAME_CYCLES);
  localparam logic [PW-1:0] VB_START  = PW'(FRAME_CYCLES - VBLANK_CYCLES);
  localparam logic [IW:0]   REG_LIMIT = (IW+1)'(REG_COUNT);

  // Stage 1: captured request
  logic                 s1_valid;
  crtc_fv_pkg::op_t     s1_op;
  logic [PW-1:0]        s1_res;
  logic [IW-1:0]        s1_idx;
  logic [DW-1:0]        s1_wval;

  // Stage 2: result of the state update; position and level are the state
  logic                 s2_valid;
  logic                 s2_rd_ok;
  logic                 s2_changed;

  // Frame state
  logic [PW-1:0]        frame_position;
  logic                 vblank_level;
  logic [REG_COUNT-1:0] reg_written;

  // Handshake between stages
  logic ready1, ready2, ready3;
  logic move12, move23;

  assign ready3    = !rsp_valid || !rsp_stall;
  assign ready2    = !s2_valid || ready3;
  assign ready1    = !s1_valid || ready2;
  assign req_stall = !ready1;
  assign move12    = s1_valid && ready2;
  assign move23    = s2_valid && ready3;

  // Fold the tick count into one frame at capture
  logic [PW-1:0] cyc_res;

  crtc_fv_modred #(
    .FRAME_CYCLES(FRAME_CYCLES)
  ) u_modred (
    .cycles (cycles),
    .residue(cyc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && req_valid) begin
      s1_op   <= crtc_fv_pkg::op_t'(operation);
      s1_res  <= cyc_res;
      s1_idx  <= reg_index;
      s1_wval <= write_value;
    end
  end

  // Position advance: one add, at most one wrap
  logic [PW:0]   pos_sum;
  logic [PW-1:0] pos_next;
  logic          vblank_next;
  logic          in_range;
  logic [AW-1:0] reg_addr;
  logic          is_tick, is_read, is_write;

  assign pos_sum  = {1'b0, frame_position} + {1'b0, s1_res};
  assign in_range = {1'b0, s1_idx} < REG_LIMIT;
  assign reg_addr = AW'(s1_idx);

  always_comb begin
    if (pos_sum >= FRAME_LEN) begin
      pos_next = PW'(pos_sum - FRAME_LEN);
    end else begin
      pos_next = PW'(pos_sum);
    end
    vblank_next = pos_next >= VB_START;
  end

  always_comb begin
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (s1_op)
      crtc_fv_pkg::OP_TICK:  is_tick  = 1'b1;
      crtc_fv_pkg::OP_READ:  is_read  = 1'b1;
      crtc_fv_pkg::OP_WRITE: is_write = 1'b1;
      default: ;
    endcase
  end

  // Register file: RAM for the data, valid bits so reset reads as zero
  logic          ram_we;
  logic [DW-1:0] ram_q;

  assign ram_we = move12 && is_write && in_range;

  crtc_fv_ram #(
    .WIDTH(DW),
    .DEPTH(REG_COUNT)
  ) u_regs (
    .clk  (clk),
    .we   (ram_we),
    .waddr(reg_addr),
    .wdata(s1_wval),
    .re   (move12),
    .raddr(reg_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_written    <= '0;
      frame_position <= '0;
      vblank_level   <= 1'b0;
      s2_valid       <= 1'b0;
    end else begin
      if (ram_we) begin
        reg_written[reg_addr] <= 1'b1;
      end
      if (move12 && is_tick) begin
        frame_position <= pos_next;
        vblank_level   <= vblank_next;
      end
      if (ready2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move12) begin
      s2_rd_ok   <= is_read && in_range && reg_written[reg_addr];
      s2_changed <= is_tick && (vblank_next != vblank_level);
    end
  end

  // Stage 3: scale position to a raster line, register the response
  logic [crtc_fv_pkg::RASTER_W-1:0] raster_next;

  crtc_fv_raster #(
    .FRAME_CYCLES(FRAME_CYCLES),
    .RASTER_COUNT(RASTER_COUNT)
  ) u_raster (
    .position(frame_position),
    .raster  (raster_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ready3) begin
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move23) begin
      read_data      <= s2_rd_ok ? ram_q : '0;
      vblank_changed <= s2_changed;
      in_vblank      <= vblank_level;
      raster         <= raster_next;
    end
  end

endmodule

### tb/sv/tb_crtc_frame_timer_with_vblank_top.sv
module tb_crtc_frame_timer_with_vblank_top;
  import crtc_fv_pkg::*;

  // Frame geometry as the block is built here (package defaults)
  localparam int unsigned FRAME_LEN   = FRAME_CYCLES_DEF;
  localparam int unsigned BLANK_LEN   = VBLANK_CYCLES_DEF;
  localparam int unsigned BLANK_START = FRAME_LEN - BLANK_LEN;
  localparam int unsigned RASTERS     = RASTER_COUNT_DEF;
  localparam int unsigned NUM_REGS    = REG_COUNT_DEF;

  // Operation code that the block must treat as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 930;
  localparam int LONG_HOLD       = 80;
  localparam int IDLE_LIMIT      = 3000;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CYC_W-1:0]  cyc;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wval;
  } crtc_request_t;

  typedef struct {
    logic [DATA_W-1:0]   rdata;
    logic                changed;
    logic                vblank;
    logic [RASTER_W-1:0] raster;
  } crtc_status_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [OP_W-1:0]     operation = '0;
  logic [CYC_W-1:0]    cycles = '0;
  logic [IDX_W-1:0]    reg_index = '0;
  logic [DATA_W-1:0]   write_value = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [DATA_W-1:0]   read_data;
  logic                vblank_changed;
  logic                in_vblank;
  logic [RASTER_W-1:0] raster;

  crtc_frame_timer_with_vblank_top dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .operation      (operation),
    .cycles         (cycles),
    .reg_index      (reg_index),
    .write_value    (write_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .read_data      (read_data),
    .vblank_changed (vblank_changed),
    .in_vblank      (in_vblank),
    .raster         (raster)
  );

  always #5 clk = ~clk;

  // Requests waiting for the driver, and the status each accepted request owes
  crtc_request_t request_backlog[$];
  crtc_status_t  crtc_status_due[$];

  // Predicted block state
  logic [POS_W-1:0]  beam_pos = '0;
  logic              blank_level = 1'b0;
  logic [DATA_W-1:0] reg_file [NUM_REGS];

  // Frame position as the stimulus planner sees it, used to aim ticks at edges
  int unsigned plan_pos = 0;

  // Handshake bookkeeping: done counters bumped at the rising edge, read at the falling
  int unsigned req_done = 0;
  int unsigned rsp_done = 0;
  int unsigned issued = 0;
  int unsigned mismatches = 0;
  int unsigned n_ticks = 0, n_edges = 0, n_reads = 0, n_writes = 0, n_unused = 0;
  int unsigned long_holds = 0;
  bit          in_long_hold = 1'b0;

  initial begin
    foreach (reg_file[i]) reg_file[i] = '0;
  end

  // Advance the predicted state by one request and return the status it owes.
  function automatic crtc_status_t crtc_step_status(crtc_request_t rq);
    crtc_status_t st;
    int unsigned  pos;
    int unsigned  scaled;
    logic         now_blank;
    st = '{rdata: '0, changed: 1'b0, vblank: 1'b0, raster: '0};
    case (rq.op)
      OP_TICK: begin
        // fold the tick into one frame first, so the position wraps at most once
        pos = int'(beam_pos) + (rq.cyc % FRAME_LEN);
        if (pos >= FRAME_LEN) pos -= FRAME_LEN;
        beam_pos = pos[POS_W-1:0];
        now_blank = (pos >= BLANK_START);
        st.changed = (now_blank != blank_level);
        blank_level = now_blank;
        n_ticks++;
        if (st.changed) n_edges++;
      end
      OP_READ: begin
        if (rq.idx < NUM_REGS) st.rdata = reg_file[rq.idx];
        n_reads++;
      end
      OP_WRITE: begin
        if (rq.idx < NUM_REGS) reg_file[rq.idx] = rq.wval;
        n_writes++;
      end
      default: begin
        n_unused++;
      end
    endcase
    st.vblank = blank_level;
    scaled = int'(beam_pos) * RASTERS / FRAME_LEN;
    st.raster = scaled[RASTER_W-1:0];
    return st;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("[%0t] %s: got %0d (0x%0h), want %0d (0x%0h)", $time, what, got, got,
             want, want);
    mismatches++;
  endtask

  // Append a request to the backlog and keep the planner's frame position current.
  task automatic queue_request(input logic [OP_W-1:0] op, input logic [CYC_W-1:0] cyc,
                               input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] wval);
    crtc_request_t rq;
    rq = '{op: op, cyc: cyc, idx: idx, wval: wval};
    request_backlog.push_back(rq);
    if (op == OP_TICK) plan_pos = (plan_pos + cyc % FRAME_LEN) % FRAME_LEN;
  endtask

  // Cycle count that lands the planned position exactly on target, optionally
  // padded with whole frames anywhere up to the top of the 32-bit range.
  function automatic logic [CYC_W-1:0] cycles_to_reach(input int unsigned target,
                                                       input bit add_frames);
    longint unsigned delta;
    longint unsigned room;
    delta = (longint'(target) + FRAME_LEN - plan_pos) % FRAME_LEN;
    if (add_frames) begin
      room = (64'hFFFF_FFFF - delta) / FRAME_LEN;
      delta += longint'(FRAME_LEN) * $urandom_range(0, int'(room));
    end
    return delta[CYC_W-1:0];
  endfunction

  // Pick a position right at a vblank boundary, the frame wrap or a raster step.
  function automatic int unsigned edge_target();
    int unsigned k;
    case ($urandom_range(0, 5))
      0: return BLANK_START - 1;
      1: return BLANK_START;
      2: return BLANK_START + $urandom_range(0, 2);
      3: return FRAME_LEN - 1 - $urandom_range(0, 1);
      4: return $urandom_range(0, 2);
      default: begin
        k = $urandom_range(1, RASTERS - 1);
        return (k * FRAME_LEN + RASTERS - 1) / RASTERS - $urandom_range(0, 1);
      end
    endcase
  endfunction

  int send_gap = 0;
  bit send_steady = 1'b0;

  // Driver: present requests at the falling edge, hold each until it is taken.
  always @(negedge clk) begin
    crtc_request_t rq;
    bit            taken;
    bit            load_next;
    int            gap;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      taken = req_valid && (req_done == issued);
      load_next = 1'b0;
      if (taken) begin
        // draw this request's gap; keep feeding during a long receiver hold
        if (in_long_hold || send_steady) gap = 0;
        else gap = $urandom_range(0, 14);
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        send_gap = gap;
        load_next = (gap == 0);
      end else if (!req_valid) begin
        if (send_gap > 0) send_gap--;
        load_next = (send_gap == 0);
      end
      if (load_next && request_backlog.size() > 0) begin
        rq = request_backlog.pop_front();
        operation   <= rq.op;
        cycles      <= rq.cyc;
        reg_index   <= rq.idx;
        write_value <= rq.wval;
        issued++;
        req_valid <= 1'b1;
      end else if (taken) begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall a random number of cycles per response, with two
  // long holds so the pipeline fills and pushes back on the request side.
  int unsigned rsp_seen = 0;
  int          hold_left = 0;
  bit          recv_steady = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_done != rsp_seen) begin
        rsp_seen = rsp_done;
        if (long_holds < 2 && rsp_done >= (long_holds + 1) * 300) begin
          hold_left = LONG_HOLD;
          in_long_hold = 1'b1;
          long_holds++;
        end else if (!in_long_hold) begin
          hold_left = recv_steady ? 0 : $urandom_range(0, 14);
          if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
        end
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= 1'b0;
        in_long_hold = 1'b0;
      end
    end
  end

  // Monitor: check responses against the oldest owed status, then predict
  // for a request taken at the same edge.
  always @(posedge clk) begin
    crtc_status_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        rsp_done <= rsp_done + 1;
        if (crtc_status_due.size() == 0) begin
          note_mismatch("response with no request outstanding", rsp_done, 0);
        end else begin
          want = crtc_status_due.pop_front();
          if (read_data !== want.rdata) note_mismatch("read_data", read_data, want.rdata);
          if (vblank_changed !== want.changed)
            note_mismatch("vblank_changed", vblank_changed, want.changed);
          if (in_vblank !== want.vblank) note_mismatch("in_vblank", in_vblank, want.vblank);
          if (raster !== want.raster) note_mismatch("raster", raster, want.raster);
        end
      end
      if (req_valid && !req_stall) begin
        req_done <= req_done + 1;
        crtc_status_due.push_back(
          crtc_step_status('{op: operation, cyc: cycles, idx: reg_index, wval: write_value}));
      end
    end
  end

  // Watchdog: end the run if no handshake completes for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("crtc_frame_timer_with_vblank_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned pick;
    int unsigned kind;
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] wv;

    // Directed: reset contents, the unused code, extreme and edge-aimed ticks,
    // register ends and out-of-range accesses.
    queue_request(OP_READ, '0, 8'd0, '0);
    queue_request(OP_UNUSED, $urandom(), 8'($urandom()), 16'($urandom()));
    queue_request(OP_TICK, 32'd0, '0, '0);
    queue_request(OP_TICK, 32'hFFFF_FFFF, '0, '0);
    queue_request(OP_TICK, cycles_to_reach(BLANK_START - 1, 1'b0), '0, '0);
    queue_request(OP_TICK, cycles_to_reach(BLANK_START, 1'b0), '0, '0);
    queue_request(OP_TICK, 32'd0, '0, '0);
    queue_request(OP_TICK, cycles_to_reach(FRAME_LEN - 1, 1'b0), '0, '0);
    queue_request(OP_TICK, 32'd1, '0, '0);
    queue_request(OP_TICK, FRAME_LEN, '0, '0);
    queue_request(OP_TICK, cycles_to_reach(BLANK_START + 3, 1'b1), '0, '0);
    queue_request(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    queue_request(OP_TICK, cycles_to_reach(5, 1'b1), '0, '0);
    queue_request(OP_WRITE, '0, 8'd0, 16'hFFFF);
    queue_request(OP_WRITE, '0, 8'(NUM_REGS - 1), 16'hA5A5);
    queue_request(OP_WRITE, '0, 8'(NUM_REGS), 16'h1234);
    queue_request(OP_WRITE, '0, 8'hFF, 16'hFFFF);
    queue_request(OP_READ, '0, 8'd0, '0);
    queue_request(OP_READ, '0, 8'(NUM_REGS - 1), '0);
    queue_request(OP_READ, '0, 8'(NUM_REGS), '0);
    queue_request(OP_READ, '0, 8'hFF, '0);
    queue_request(OP_WRITE, '0, 8'd0, 16'h0000);
    queue_request(OP_READ, '0, 8'd0, '0);

    // Random: half ticks, many of them aimed at edges, mixed with register traffic.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 99);
      idx = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 31));
      case ($urandom_range(0, 5))
        0: wv = '0;
        1: wv = '1;
        default: wv = 16'($urandom());
      endcase
      if (pick < 50) begin
        kind = $urandom_range(0, 9);
        if (kind < 3) queue_request(OP_TICK, $urandom_range(0, 2000), idx, wv);
        else if (kind < 6)
          queue_request(OP_TICK, cycles_to_reach(edge_target(), kind[0]), idx, wv);
        else if (kind < 9) queue_request(OP_TICK, $urandom(), idx, wv);
        else queue_request(OP_TICK, FRAME_LEN * $urandom_range(0, 3) + $urandom_range(0, 3),
                           idx, wv);
      end else if (pick < 70) begin
        queue_request(OP_READ, $urandom(), idx, wv);
      end else if (pick < 95) begin
        queue_request(OP_WRITE, $urandom(), idx, wv);
      end else begin
        queue_request(OP_UNUSED, $urandom(), idx, wv);
      end
    end

    // Hold reset, then drop it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and every owed status to come back,
    // then leave time for stray responses.
    while (request_backlog.size() != 0 || issued != req_done) @(posedge clk);
    while (crtc_status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (crtc_status_due.size() != 0)
      note_mismatch("requests left without a response", crtc_status_due.size(), 0);

    $display("%0d requests: %0d ticks, %0d vblank toggles, %0d reads, %0d writes, %0d no-ops",
             req_done, n_ticks, n_edges, n_reads, n_writes, n_unused);
    $display("checked %0d responses across %0d long receiver holds, %0d mismatches",
             rsp_done, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("crtc_frame_timer_with_vblank_top: match");
    end else begin
      $display("crtc_frame_timer_with_vblank_top: mismatch");
    end
    $finish;
  end

endmodule
